/* hdl/assert_macros.svh */
// Assertion macros used by the top level of the framed link sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/flsa_pkg.sv */
// Package with the types, constants and CRC function of the framed link sender.
`timescale 1ns / 1ps
`default_nettype none
package flsa_pkg;

  localparam int CHUNK_BYTES_DEF = 64;
  localparam int CFG_AW = 1;
  localparam int OQ_DEPTH = 4;

  localparam logic [CFG_AW-1:0] REG_MAX_ATTEMPTS = 1'd0;
  localparam logic [CFG_AW-1:0] REG_REPLY_TIMEOUT = 1'd1;

  localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd8;
  localparam logic [31:0] REPLY_TIMEOUT_RST = 32'd2500;

  localparam logic [7:0] SYNC0 = 8'h55;
  localparam logic [7:0] SYNC1 = 8'hAA;
  localparam logic [7:0] ACK_BYTE = 8'h06;
  localparam logic [7:0] HDR0 = 8'h53;
  localparam logic [7:0] HDR1 = 8'h5A;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_PAYLOAD = 3'd1;
  localparam logic [2:0] CMD_READY = 3'd2;
  localparam logic [2:0] CMD_REPLY = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_HDR_SEND = 3'd1;
  localparam logic [2:0] PH_HDR_WAIT = 3'd2;
  localparam logic [2:0] PH_LOAD = 3'd3;
  localparam logic [2:0] PH_FRM_SEND = 3'd4;
  localparam logic [2:0] PH_REPLY_WAIT = 3'd5;
  localparam logic [2:0] PH_FINISHED = 3'd6;

  localparam logic [2:0] OUT_NONE = 3'd0;
  localparam logic [2:0] OUT_DONE = 3'd1;
  localparam logic [2:0] OUT_HDR_TIMEOUT = 3'd2;
  localparam logic [2:0] OUT_HDR_REFUSED = 3'd3;
  localparam logic [2:0] OUT_RETRIES = 3'd4;

  typedef enum logic [2:0] {
    K_START,
    K_PAYLOAD,
    K_READY,
    K_REPLY,
    K_TICK,
    K_NONE
  } item_kind_t;

  typedef struct packed {
    item_kind_t kind;
    logic [31:0] file_size;
    logic [7:0] data_byte;
  } item_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_HDR_SEND = 7'b0000010,
    ST_HDR_WAIT = 7'b0000100,
    ST_LOAD = 7'b0001000,
    ST_FRM_SEND = 7'b0010000,
    ST_REPLY_WAIT = 7'b0100000,
    ST_FINISHED = 7'b1000000
  } state_t;

  typedef struct packed {
    logic tx_valid;
    logic [7:0] tx_byte;
    logic frame_end;
    logic accepted;
    logic [2:0] phase;
    logic [2:0] outcome;
    logic [15:0] sequence_res;
    logic [3:0] attempt;
    logic frame_acked;
  } result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [2:0] phase_code(input state_t st);
    logic [2:0] code;
    case (st)
      ST_IDLE: code = PH_IDLE;
      ST_HDR_SEND: code = PH_HDR_SEND;
      ST_HDR_WAIT: code = PH_HDR_WAIT;
      ST_LOAD: code = PH_LOAD;
      ST_FRM_SEND: code = PH_FRM_SEND;
      ST_REPLY_WAIT: code = PH_REPLY_WAIT;
      ST_FINISHED: code = PH_FINISHED;
      default: code = PH_IDLE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

/* hdl/flsa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module flsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [AW-1:0] waddr,
  input wire logic [WIDTH-1:0] wdata,
  input wire logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hdl/flsa_front.sv */
// Input queue that takes command beats and classifies them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module flsa_front import flsa_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire logic [2:0] cmd,
  input wire logic [31:0] file_size,
  input wire logic [7:0] data_byte,
  output logic valid,
  output item_t item,
  input wire logic take
);
  item_t slots [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  item_kind_t kind;
  logic do_push;
  logic do_pop;

  always_comb begin
    case (cmd)
      CMD_START: kind = K_START;
      CMD_PAYLOAD: kind = K_PAYLOAD;
      CMD_READY: kind = K_READY;
      CMD_REPLY: kind = K_REPLY;
      CMD_TICK: kind = K_TICK;
      default: kind = K_NONE;
    endcase
  end

  assign full = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign item = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = take && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{kind: kind, file_size: file_size, data_byte: data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule
`default_nettype wire

/* hdl/flsa_outq.sv */
// Result queue that holds finished result beats until they are popped.
`timescale 1ns / 1ps
`default_nettype none
module flsa_outq import flsa_pkg::*; #(
  parameter int DEPTH = OQ_DEPTH,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic wr,
  input wire result_t wdata,
  output logic empty,
  input wire logic pop,
  output result_t rdata,
  output logic [CW-1:0] count
);
  result_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic do_pop;

  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CW'(wr) - CW'(do_pop);
    end
  end
endmodule
`default_nettype wire

/* hdl/flsa_engine.sv */
// Transfer engine: header, frame loading, frame sending, replies and retries.
`timescale 1ns / 1ps
`default_nettype none
module flsa_engine import flsa_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  localparam int AW = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1,
  localparam int LW = $clog2(CHUNK_BYTES + 1),
  localparam int PW = $clog2(CHUNK_BYTES + 8),
  localparam int QW = $clog2(OQ_DEPTH + 1)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_wr_en,
  input wire logic [CFG_AW-1:0] cfg_addr,
  input wire logic [31:0] cfg_wdata,
  input wire logic in_valid,
  input wire item_t item,
  output logic take,
  input wire logic [QW-1:0] oq_count,
  output logic res_wr,
  output result_t res
);
  logic [3:0] max_attempts;
  logic [31:0] reply_timeout;

  state_t st, st_next;
  logic [31:0] total_size, total_size_next;
  logic [31:0] remaining, remaining_next;
  logic [15:0] frame_seq, frame_seq_next;
  logic [LW-1:0] frame_len, frame_len_next;
  logic [LW-1:0] fill_count, fill_count_next;
  logic [PW-1:0] send_pos, send_pos_next;
  logic [15:0] crc, crc_next;
  logic [3:0] attempt_cnt, attempt_cnt_next;
  logic [1:0] reply_cnt, reply_cnt_next;
  logic reply_ok, reply_ok_next;
  logic [7:0] echo_low, echo_low_next;
  logic [31:0] wait_ticks, wait_ticks_next;
  logic [2:0] held, held_next;

  result_t s1_res;
  logic s1_use_ram;
  result_t s2_res;
  logic s2_use_ram;
  logic s2_valid;

  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0] ram_rdata;
  logic [31:0] wt_inc;
  logic expired;
  logic [31:0] rem_after;
  logic [PW-1:0] len_p;
  logic [15:0] len16;

  assign take = in_valid && ((32'(oq_count) + 32'(s2_valid)) < 32'(OQ_DEPTH));
  assign wt_inc = (wait_ticks == 32'hFFFF_FFFF) ? wait_ticks : wait_ticks + 32'd1;
  assign expired = (wt_inc >= reply_timeout);
  assign rem_after = remaining - 32'(frame_len);
  assign len_p = PW'(frame_len);
  assign len16 = 16'(frame_len);
  assign ram_we = take && (item.kind == K_PAYLOAD) && (st == ST_LOAD)
      && (fill_count < frame_len);
  assign ram_raddr = AW'(send_pos - PW'(6));

  flsa_ram #(.WIDTH(8), .DEPTH(CHUNK_BYTES)) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(AW'(fill_count)),
    .wdata(item.data_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    st_next = st;
    total_size_next = total_size;
    remaining_next = remaining;
    frame_seq_next = frame_seq;
    frame_len_next = frame_len;
    fill_count_next = fill_count;
    send_pos_next = send_pos;
    crc_next = crc;
    attempt_cnt_next = attempt_cnt;
    reply_cnt_next = reply_cnt;
    reply_ok_next = reply_ok;
    echo_low_next = echo_low;
    wait_ticks_next = wait_ticks;
    held_next = held;
    s1_res = '0;
    s1_use_ram = 1'b0;

    case (item.kind)
      K_START: begin
        if (st == ST_IDLE || st == ST_FINISHED) begin
          total_size_next = item.file_size;
          remaining_next = item.file_size;
          frame_seq_next = '0;
          attempt_cnt_next = '0;
          send_pos_next = '0;
          held_next = OUT_NONE;
          st_next = ST_HDR_SEND;
        end
      end
      K_PAYLOAD: begin
        if (ram_we) begin
          crc_next = crc_update(crc, item.data_byte);
          fill_count_next = fill_count + 1'b1;
          s1_res.accepted = 1'b1;
          if (fill_count + 1'b1 >= frame_len) begin
            send_pos_next = '0;
            st_next = ST_FRM_SEND;
          end
        end
      end
      K_READY: begin
        if (st == ST_HDR_SEND) begin
          s1_res.tx_valid = 1'b1;
          if (send_pos == PW'(0)) s1_res.tx_byte = HDR0;
          else if (send_pos == PW'(1)) s1_res.tx_byte = HDR1;
          else if (send_pos == PW'(2)) s1_res.tx_byte = total_size[7:0];
          else if (send_pos == PW'(3)) s1_res.tx_byte = total_size[15:8];
          else if (send_pos == PW'(4)) s1_res.tx_byte = total_size[23:16];
          else s1_res.tx_byte = total_size[31:24];
          if (send_pos >= PW'(5)) begin
            s1_res.frame_end = 1'b1;
            wait_ticks_next = '0;
            st_next = ST_HDR_WAIT;
          end else begin
            send_pos_next = send_pos + 1'b1;
          end
        end else if (st == ST_FRM_SEND) begin
          s1_res.tx_valid = 1'b1;
          if (send_pos == PW'(0)) s1_res.tx_byte = SYNC0;
          else if (send_pos == PW'(1)) s1_res.tx_byte = SYNC1;
          else if (send_pos == PW'(2)) s1_res.tx_byte = frame_seq[7:0];
          else if (send_pos == PW'(3)) s1_res.tx_byte = frame_seq[15:8];
          else if (send_pos == PW'(4)) s1_res.tx_byte = len16[7:0];
          else if (send_pos == PW'(5)) s1_res.tx_byte = len16[15:8];
          else if (send_pos < len_p + PW'(6)) s1_use_ram = 1'b1;
          else if (send_pos == len_p + PW'(6)) s1_res.tx_byte = crc[7:0];
          else s1_res.tx_byte = crc[15:8];
          if (send_pos >= len_p + PW'(7)) begin
            s1_res.frame_end = 1'b1;
            if (attempt_cnt != 4'hF) attempt_cnt_next = attempt_cnt + 1'b1;
            reply_cnt_next = '0;
            reply_ok_next = 1'b0;
            wait_ticks_next = '0;
            st_next = ST_REPLY_WAIT;
          end else begin
            send_pos_next = send_pos + 1'b1;
          end
        end
      end
      K_REPLY: begin
        if (st == ST_HDR_WAIT) begin
          if (item.data_byte == ACK_BYTE) begin
            if (remaining == '0) begin
              st_next = ST_FINISHED;
              held_next = OUT_DONE;
            end else begin
              frame_len_next = (remaining > 32'(CHUNK_BYTES)) ? LW'(CHUNK_BYTES)
                  : LW'(remaining);
              fill_count_next = '0;
              crc_next = CRC_INIT;
              attempt_cnt_next = '0;
              st_next = ST_LOAD;
            end
          end else begin
            st_next = ST_FINISHED;
            held_next = OUT_HDR_REFUSED;
          end
        end else if (st == ST_REPLY_WAIT) begin
          if (reply_cnt == 2'd0) begin
            reply_ok_next = (item.data_byte == ACK_BYTE);
            reply_cnt_next = 2'd1;
          end else if (reply_cnt == 2'd1) begin
            echo_low_next = item.data_byte;
            reply_cnt_next = 2'd2;
          end else begin
            reply_cnt_next = 2'd0;
            if (reply_ok && ({item.data_byte, echo_low} == frame_seq)) begin
              s1_res.frame_acked = 1'b1;
              remaining_next = rem_after;
              frame_seq_next = frame_seq + 16'd1;
              if (rem_after == '0) begin
                st_next = ST_FINISHED;
                held_next = OUT_DONE;
              end else begin
                frame_len_next = (rem_after > 32'(CHUNK_BYTES)) ? LW'(CHUNK_BYTES)
                    : LW'(rem_after);
                fill_count_next = '0;
                crc_next = CRC_INIT;
                attempt_cnt_next = '0;
                st_next = ST_LOAD;
              end
            end else if (attempt_cnt >= max_attempts) begin
              st_next = ST_FINISHED;
              held_next = OUT_RETRIES;
            end else begin
              send_pos_next = '0;
              st_next = ST_FRM_SEND;
            end
          end
        end
      end
      K_TICK: begin
        if (st == ST_HDR_WAIT) begin
          wait_ticks_next = wt_inc;
          if (expired) begin
            st_next = ST_FINISHED;
            held_next = OUT_HDR_TIMEOUT;
          end
        end else if (st == ST_REPLY_WAIT) begin
          wait_ticks_next = wt_inc;
          if (expired) begin
            reply_cnt_next = '0;
            if (attempt_cnt >= max_attempts) begin
              st_next = ST_FINISHED;
              held_next = OUT_RETRIES;
            end else begin
              send_pos_next = '0;
              st_next = ST_FRM_SEND;
            end
          end
        end
      end
      default: begin
      end
    endcase

    s1_res.phase = phase_code(st_next);
    s1_res.outcome = (st_next == ST_FINISHED) ? held_next : OUT_NONE;
    s1_res.sequence_res = s1_res.frame_acked ? frame_seq : frame_seq_next;
    s1_res.attempt = s1_res.frame_acked ? attempt_cnt : attempt_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts <= MAX_ATTEMPTS_RST;
      reply_timeout <= REPLY_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_MAX_ATTEMPTS: max_attempts <= cfg_wdata[3:0];
        REG_REPLY_TIMEOUT: reply_timeout <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      total_size <= '0;
      remaining <= '0;
      frame_seq <= '0;
      frame_len <= '0;
      fill_count <= '0;
      send_pos <= '0;
      crc <= CRC_INIT;
      attempt_cnt <= '0;
      reply_cnt <= '0;
      reply_ok <= 1'b0;
      echo_low <= '0;
      wait_ticks <= '0;
      held <= OUT_NONE;
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= take;
      if (take) begin
        st <= st_next;
        total_size <= total_size_next;
        remaining <= remaining_next;
        frame_seq <= frame_seq_next;
        frame_len <= frame_len_next;
        fill_count <= fill_count_next;
        send_pos <= send_pos_next;
        crc <= crc_next;
        attempt_cnt <= attempt_cnt_next;
        reply_cnt <= reply_cnt_next;
        reply_ok <= reply_ok_next;
        echo_low <= echo_low_next;
        wait_ticks <= wait_ticks_next;
        held <= held_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_res <= s1_res;
      s2_use_ram <= s1_use_ram;
    end
  end

  always_comb begin
    res = s2_res;
    if (s2_use_ram) res.tx_byte = ram_rdata;
  end
  assign res_wr = s2_valid;
endmodule
`default_nettype wire

/* hdl/framed_link_sender_arq.sv */
// Top level of the stop-and-wait framed link sender.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Every command beat (start, payload byte, link ready, reply byte, tick) yields exactly one
// result beat. The block takes one command beat per clock cycle for as long as results are
// popped; a result passes through the input queue and then the transfer engine's output
// register, which the registered read of the payload RAM runs alongside, and then it waits
// in a four-entry result queue. Configuration writes take effect at once.
module framed_link_sender_arq import flsa_pkg::*; #(
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
  localparam int QW = $clog2(OQ_DEPTH + 1)
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic cfg_wr_en,
  input wire logic [CFG_AW-1:0] cfg_addr,
  input wire logic [31:0] cfg_wdata,
  input wire logic push,
  output logic full,
  input wire logic [2:0] cmd,
  input wire logic [31:0] file_size,
  input wire logic [7:0] data_byte,
  output logic empty,
  input wire logic pop,
  output logic tx_valid,
  output logic [7:0] tx_byte,
  output logic frame_end,
  output logic accepted,
  output logic [2:0] phase,
  output logic [2:0] outcome,
  output logic [15:0] sequence_res,
  output logic [3:0] attempt,
  output logic frame_acked
);
  logic fr_valid;
  item_t fr_item;
  logic take;
  logic [QW-1:0] oq_count;
  logic res_wr;
  result_t res;
  result_t head;

  flsa_front u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cmd(cmd),
    .file_size(file_size),
    .data_byte(data_byte),
    .valid(fr_valid),
    .item(fr_item),
    .take(take)
  );

  flsa_engine #(.CHUNK_BYTES(CHUNK_BYTES)) u_engine (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(fr_valid),
    .item(fr_item),
    .take(take),
    .oq_count(oq_count),
    .res_wr(res_wr),
    .res(res)
  );

  flsa_outq #(.DEPTH(OQ_DEPTH)) u_outq (
    .clk(clk),
    .rst(rst),
    .wr(res_wr),
    .wdata(res),
    .empty(empty),
    .pop(pop),
    .rdata(head),
    .count(oq_count)
  );

  assign tx_valid = head.tx_valid;
  assign tx_byte = head.tx_byte;
  assign frame_end = head.frame_end;
  assign accepted = head.accepted;
  assign phase = head.phase;
  assign outcome = head.outcome;
  assign sequence_res = head.sequence_res;
  assign attempt = head.attempt;
  assign frame_acked = head.frame_acked;

  `ASSERT_IMPLIES(a_outcome_finished, clk, rst, !empty && outcome != OUT_NONE,
      phase == PH_FINISHED)
  `ASSERT_IMPLIES(a_idle_tx_zero, clk, rst, !empty && !tx_valid,
      tx_byte == 8'h00 && frame_end == 1'b0)
  `ASSERT_IMPLIES(a_ack_moves_on, clk, rst, !empty && frame_acked,
      phase == PH_LOAD || phase == PH_FINISHED)
  `ASSERT_NEXT(a_result_follows, clk, rst, take, res_wr)
endmodule
`default_nettype wire
